// ===== rtl/stfe_pkg.sv =====
// shared types and constants of the sine tone generator with fade envelope
`timescale 1ns / 1ps
`default_nettype none

package stfe_pkg;

	localparam int FRAME_W    = 48;
	localparam int SAMPLE_W   = 16;
	localparam int CHAN_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int INC_W   = 32;
	localparam int FADE_W  = 16;
	localparam int GAIN_W  = 16;
	localparam int COUNT_W = 4;
	localparam int MAG_W   = 15;

	localparam logic [INC_W-1:0]   INC_RESET   = 32'd39370534;
	localparam logic [FADE_W-1:0]  FADE_RESET  = 16'd960;
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd13107;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd2;

	localparam longint unsigned Q30_ONE     = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned SINE_SCALE  = 64'd32767;

	localparam int TAYLOR_TERMS = 6;
	localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] = '{
		64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_INC  = 3'd0,
		REG_FADE_LEN   = 3'd1,
		REG_BASE_GAIN  = 3'd2,
		REG_CHAN_COUNT = 3'd3
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/stfe_ifs.sv =====
// valid/ready channel interfaces for frame requests and channel samples
`timescale 1ns / 1ps
`default_nettype none

interface stfe_in_if;
	logic                          valid;
	logic                          ready;
	logic [stfe_pkg::FRAME_W-1:0]  frame_num;
	logic                          stop_armed;
	logic [stfe_pkg::FRAME_W-1:0]  stop_frame;

	modport source (output valid, output frame_num, output stop_armed,
		output stop_frame, input ready);
	modport sink (input valid, input frame_num, input stop_armed,
		input stop_frame, output ready);
endinterface

interface stfe_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [stfe_pkg::SAMPLE_W-1:0] sample;
	logic [stfe_pkg::CHAN_W-1:0]          channel;
	logic                                last_channel;

	modport source (output valid, output sample, output channel,
		output last_channel, input ready);
	modport sink (input valid, input sample, input channel,
		input last_channel, output ready);
endinterface

`default_nettype wire

// ===== rtl/sine_tone_with_fade_envelope_top.sv =====
// top level: pipelined sine tone generator with linear fade in/out and channel fan-out
//
// in_ch carries one transaction per frame: frame_num, stop_armed, stop_frame.
// out_ch carries one transaction per output channel of that frame, channel 0 first,
// last_channel set on the final one; channel_count of zero gives no output.
// configuration is written through cfg_we / cfg_index / cfg_data while idle; the user
// must keep to that, the block itself does not enforce it.
// the pipeline has 6 arithmetic stages, 16 one-bit divider stages and the output
// register; stage 1 loads at the edge that takes the input transaction.
// with zero or one channel configured it takes one frame per cycle unless the
// receiver stalls; otherwise the output register repeats the sample once per channel
// (at most MAX_CHANNELS) before it takes the next frame.
// the pipeline advances as one: while the output register holds a frame and the
// receiver stalls, the stages keep moving until a frame waits at the divider tail,
// then in_ch.ready drops; nothing is lost or repeated.
// reset clears all valid bits and loads the default configuration
// (440 Hz at 48 kHz, 960 frame fades, gain 0.2, two channels).
`timescale 1ns / 1ps
`default_nettype none

module sine_tone_with_fade_envelope_top #(
	parameter int MAX_CHANNELS     = 8,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	stfe_in_if.sink                             in_ch,
	stfe_out_if.source                          out_ch,
	input  wire                                 cfg_we,
	input  wire [stfe_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [stfe_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AW     = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
	localparam int N_W    = $clog2(MAX_CHANNELS + 1);
	localparam int Q_W    = 16;
	localparam int NUM_W  = 63;
	localparam int REM_W  = 64;
	localparam int DV_W   = 48;
	localparam int KP_W   = 30 + AW + 1;
	localparam longint unsigned ROM_DEN = 2 * SINE_TABLE_DEPTH;

	typedef logic [stfe_pkg::MAG_W-1:0] rom_t [SINE_TABLE_DEPTH];

	function automatic rom_t build_rom();
		rom_t r;
		longint unsigned a;
		longint unsigned a2;
		longint unsigned t;
		longint unsigned p;
		longint unsigned s;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			a  = (stfe_pkg::HALF_PI_Q30 * (2 * longint'(k) + 1) + ROM_DEN / 2) / ROM_DEN;
			a2 = (a * a) >> 30;
			t  = stfe_pkg::Q30_ONE;
			for (int i = 0; i < stfe_pkg::TAYLOR_TERMS; i++) begin
				p = ((a2 * t) >> 30) / stfe_pkg::TAYLOR_DIV[i];
				t = (p >= stfe_pkg::Q30_ONE) ? 64'd0 : (stfe_pkg::Q30_ONE - p);
			end
			s = (a * t) >> 30;
			r[k] = stfe_pkg::MAG_W'((s * stfe_pkg::SINE_SCALE + (stfe_pkg::Q30_ONE >> 1)) >> 30);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// configuration
	logic [stfe_pkg::INC_W-1:0]   inc_q;
	logic [stfe_pkg::FADE_W-1:0]  fade_q;
	logic [stfe_pkg::GAIN_W-1:0]  gain_q;
	logic [stfe_pkg::COUNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_q   <= stfe_pkg::INC_RESET;
			fade_q  <= stfe_pkg::FADE_RESET;
			gain_q  <= stfe_pkg::GAIN_RESET;
			count_q <= stfe_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			unique case (stfe_pkg::cfg_reg_t'(cfg_index))
				stfe_pkg::REG_PHASE_INC:  inc_q   <= cfg_data[stfe_pkg::INC_W-1:0];
				stfe_pkg::REG_FADE_LEN:   fade_q  <= cfg_data[stfe_pkg::FADE_W-1:0];
				stfe_pkg::REG_BASE_GAIN:  gain_q  <= cfg_data[stfe_pkg::GAIN_W-1:0];
				stfe_pkg::REG_CHAN_COUNT: count_q <= cfg_data[stfe_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline registers
	logic                          v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [31:0]                   phase_s1;
	logic                          fin_s1, fo_s1;
	logic [stfe_pkg::FADE_W-1:0]   n1_s1;
	logic [stfe_pkg::FRAME_W-1:0]  d_s1;

	logic [AW-1:0]                 k_s2;
	logic                          neg_s2;
	logic [15:0]                   n1_s2, d1_s2, n2_s2, d2_s2;

	logic [stfe_pkg::MAG_W-1:0]    mag_s3;
	logic                          neg_s3;
	logic [31:0]                   gn1_s3, dd_s3;
	logic [15:0]                   n2_s3;

	logic [stfe_pkg::MAG_W-1:0]    mag_s4;
	logic                          neg_s4;
	logic [47:0]                   gn12_s4;
	logic [31:0]                   dd_s4;

	logic                          neg_s5;
	logic [NUM_W-1:0]              num_s5;
	logic [31:0]                   dd_s5;

	logic                          neg_s6;
	logic [REM_W-1:0]              rem_s6;
	logic [DV_W-1:0]               dv_s6;

	logic                          div_v_sd   [Q_W];
	logic                          div_neg_sd [Q_W];
	logic [REM_W-1:0]              div_rem_sd [Q_W];
	logic [DV_W-1:0]               div_dv_sd  [Q_W];
	logic [Q_W-1:0]                div_q_sd   [Q_W];

	// output register
	logic                          exp_v_q;
	logic [N_W-1:0]                exp_cnt_q;
	logic [N_W-1:0]                exp_n_q;
	logic signed [stfe_pkg::SAMPLE_W-1:0] exp_sample_q;

	logic                          exp_last;
	logic                          exp_take;
	logic                          adv;
	logic [N_W-1:0]                n_eff;
	logic [Q_W-1:0]                q_fin;
	logic signed [stfe_pkg::SAMPLE_W-1:0] sat_sample;

	logic                          s2_zero;
	logic [KP_W-1:0]               k_prod;
	logic [AW-1:0]                 k_raw;

	assign exp_last = (exp_cnt_q + N_W'(1)) == exp_n_q;
	assign exp_take = !exp_v_q || (out_ch.ready && exp_last);
	assign adv      = !div_v_sd[Q_W-1] || exp_take;
	assign in_ch.ready = adv;

	assign n_eff = (int'(count_q) > MAX_CHANNELS) ? N_W'(MAX_CHANNELS) : N_W'(count_q);

	assign s2_zero = fo_s1 && ((fade_q == '0) || (d_s1 >= stfe_pkg::FRAME_W'(fade_q)));
	assign k_prod  = KP_W'(phase_s1[29:0]) * KP_W'(SINE_TABLE_DEPTH);
	assign k_raw   = k_prod[30 +: AW];

	assign q_fin = div_q_sd[Q_W-1];

	always_comb begin
		if (div_neg_sd[Q_W-1]) begin
			if (q_fin > 16'd32768) sat_sample = 16'sh8000;
			else                   sat_sample = -$signed(q_fin);
		end else begin
			if (q_fin > 16'd32767) sat_sample = 16'sh7fff;
			else                   sat_sample = $signed(q_fin);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int i = 0; i < Q_W; i++) div_v_sd[i] <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			div_v_sd[0] <= v_s6;
			for (int i = 1; i < Q_W; i++) div_v_sd[i] <= div_v_sd[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// phase and fade conditions
			phase_s1 <= in_ch.frame_num[31:0] * inc_q;
			fin_s1   <= (fade_q != '0) && (in_ch.frame_num < stfe_pkg::FRAME_W'(fade_q));
			n1_s1    <= in_ch.frame_num[stfe_pkg::FADE_W-1:0];
			fo_s1    <= in_ch.stop_armed && (in_ch.frame_num >= in_ch.stop_frame);
			d_s1     <= in_ch.frame_num - in_ch.stop_frame;

			// table address and gain ratios
			k_s2   <= phase_s1[30] ? (AW'(SINE_TABLE_DEPTH - 1) - k_raw) : k_raw;
			neg_s2 <= phase_s1[31];
			n1_s2  <= fin_s1 ? n1_s1 : 16'd1;
			d1_s2  <= fin_s1 ? fade_q : 16'd1;
			n2_s2  <= !fo_s1 ? 16'd1 : (s2_zero ? 16'd0 : (fade_q - d_s1[15:0]));
			d2_s2  <= (fo_s1 && !s2_zero) ? fade_q : 16'd1;

			// table read and first products
			mag_s3 <= SINE_ROM[k_s2];
			neg_s3 <= neg_s2;
			gn1_s3 <= 32'(gain_q) * 32'(n1_s2);
			dd_s3  <= 32'(d1_s2) * 32'(d2_s2);
			n2_s3  <= n2_s2;

			mag_s4  <= mag_s3;
			neg_s4  <= neg_s3;
			gn12_s4 <= 48'(gn1_s3) * 48'(n2_s3);
			dd_s4   <= dd_s3;

			neg_s5 <= neg_s4;
			num_s5 <= NUM_W'(gn12_s4) * NUM_W'(mag_s4);
			dd_s5  <= dd_s4;

			// rounding offset of half the divisor
			neg_s6 <= neg_s5;
			rem_s6 <= REM_W'(num_s5) + (REM_W'(dd_s5) << 15);
			dv_s6  <= {dd_s5, 16'b0};

			// restoring divider, one quotient bit per stage
			for (int i = 0; i < Q_W; i++) begin
				logic [REM_W-1:0] r_in;
				logic [DV_W-1:0]  dv_in;
				logic [Q_W-1:0]   q_in;
				logic             n_in;
				logic [REM_W:0]   diff;
				if (i == 0) begin
					r_in  = rem_s6;
					dv_in = dv_s6;
					q_in  = '0;
					n_in  = neg_s6;
				end else begin
					r_in  = div_rem_sd[i-1];
					dv_in = div_dv_sd[i-1];
					q_in  = div_q_sd[i-1];
					n_in  = div_neg_sd[i-1];
				end
				diff = {1'b0, r_in} - ({1'b0, REM_W'(dv_in)} << (Q_W - 1 - i));
				div_dv_sd[i]  <= dv_in;
				div_neg_sd[i] <= n_in;
				if (!diff[REM_W]) begin
					div_rem_sd[i] <= diff[REM_W-1:0];
					div_q_sd[i]   <= q_in | (Q_W'(1) << (Q_W - 1 - i));
				end else begin
					div_rem_sd[i] <= r_in;
					div_q_sd[i]   <= q_in;
				end
			end
		end
	end

	// channel fan-out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_v_q   <= 1'b0;
			exp_cnt_q <= '0;
			exp_n_q   <= '0;
		end else if (exp_take) begin
			exp_v_q   <= div_v_sd[Q_W-1] && (n_eff != '0);
			exp_cnt_q <= '0;
			exp_n_q   <= n_eff;
		end else if (out_ch.ready) begin
			exp_cnt_q <= exp_cnt_q + N_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (exp_take) exp_sample_q <= sat_sample;
	end

	assign out_ch.valid        = exp_v_q;
	assign out_ch.sample       = exp_sample_q;
	assign out_ch.channel      = stfe_pkg::CHAN_W'(exp_cnt_q);
	assign out_ch.last_channel = exp_last;

endmodule

`default_nettype wire

// ===== rtl/stfe_checker.sv =====
// port-level checks of the tone generator and their bind to the top level
`timescale 1ns / 1ps
`default_nettype none

module stfe_checker (
	input wire                                  clk,
	input wire                                  arst_n,
	input wire                                  in_ready,
	input wire                                  out_valid,
	input wire                                  out_ready,
	input wire signed [stfe_pkg::SAMPLE_W-1:0]  out_sample,
	input wire [stfe_pkg::CHAN_W-1:0]           out_channel,
	input wire                                  out_last
);

	// stalled transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_sample)
			&& $stable(out_channel) && $stable(out_last))
		else $error("output changed while stalled");

	// channels of one frame follow each other without a gap
	a_chan_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid
			&& (out_channel == $past(out_channel) + 3'd1)
			&& (out_sample == $past(out_sample)))
		else $error("channel sequence broken");

	// an empty output register never blocks the input
	a_ready_idle: assert property (@(posedge clk) !out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// gain never exceeds unity, so the negative limit is unreachable
	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_sample != 16'sh8000)
		else $error("sample reached negative full scale");

endmodule

bind sine_tone_with_fade_envelope_top stfe_checker u_stfe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.out_sample  (out_ch.sample),
	.out_channel (out_ch.channel),
	.out_last    (out_ch.last_channel)
);

`default_nettype wire

// ===== sim/sine_tone_with_fade_envelope_top_test.sv =====
// self-checking testbench of the sine tone generator with fade envelope
`timescale 1ns / 1ps

module sine_tone_with_fade_envelope_top_test;

	localparam int CHANNELS_MAX  = 8;
	localparam int TABLE_DEPTH   = 1024;
	localparam int TABLE_AW      = $clog2(TABLE_DEPTH);
	localparam int SETTLE_CYCLES = 40;
	localparam int MAX_GAP       = 20;

	typedef struct {
		logic signed [stfe_pkg::SAMPLE_W-1:0] sample;
		logic [stfe_pkg::CHAN_W-1:0]          channel;
		logic                                 last_channel;
	} chan_sample_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_we;
	logic [stfe_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [stfe_pkg::CFG_DATA_W-1:0] cfg_data;

	stfe_in_if  in_ch ();
	stfe_out_if out_ch ();

	sine_tone_with_fade_envelope_top #(
		.MAX_CHANNELS     (CHANNELS_MAX),
		.SINE_TABLE_DEPTH (TABLE_DEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow copy of the configuration registers
	logic [stfe_pkg::INC_W-1:0]   phase_inc;
	logic [stfe_pkg::FADE_W-1:0]  fade_len;
	logic [stfe_pkg::GAIN_W-1:0]  gain;
	logic [stfe_pkg::COUNT_W-1:0] chan_count;

	logic [stfe_pkg::MAG_W-1:0] quarter_sine_lut [TABLE_DEPTH];
	chan_sample_t               pending_channel_samples [$];

	int tx_idle_pct;
	int rx_stall_pct;
	int hold_off_cycles;
	int mismatch_count;
	int frames_sent;
	int samples_checked;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [stfe_pkg::MAG_W-1:0] quarter_wave(int unsigned k);
		longint unsigned a, a2, t, p, s, den;
		den = 64'(2 * TABLE_DEPTH);
		a = (stfe_pkg::HALF_PI_Q30 * (64'(k) * 64'd2 + 64'd1) + den / 64'd2) / den;
		a2 = (a * a) >> 30;
		t = stfe_pkg::Q30_ONE;
		for (int i = 0; i < stfe_pkg::TAYLOR_TERMS; i++) begin
			p = ((a2 * t) >> 30) / stfe_pkg::TAYLOR_DIV[i];
			t = (p >= stfe_pkg::Q30_ONE) ? 64'd0 : (stfe_pkg::Q30_ONE - p);
		end
		s = (a * t) >> 30;
		return stfe_pkg::MAG_W'((s * stfe_pkg::SINE_SCALE + (stfe_pkg::Q30_ONE >> 1)) >> 30);
	endfunction

	function automatic logic signed [stfe_pkg::SAMPLE_W-1:0] tone_sample(
		logic [stfe_pkg::FRAME_W-1:0] frame, logic armed, logic [stfe_pkg::FRAME_W-1:0] stop);
		logic [stfe_pkg::INC_W-1:0] phase;
		longint unsigned low, k, mag, n1, d1, n2, d2, past_stop, num, dv, q;
		phase = frame[stfe_pkg::INC_W-1:0] * phase_inc;
		low = 64'(phase[29:0]);
		k = (low * 64'(TABLE_DEPTH)) >> 30;
		if (k >= 64'(TABLE_DEPTH))
			k = 64'(TABLE_DEPTH - 1);
		if (phase[30])
			k = 64'(TABLE_DEPTH - 1) - k;
		mag = 64'(quarter_sine_lut[k[TABLE_AW-1:0]]);
		n1 = 64'd1;
		d1 = 64'd1;
		n2 = 64'd1;
		d2 = 64'd1;
		if (fade_len != '0 && frame < stfe_pkg::FRAME_W'(fade_len)) begin
			n1 = 64'(frame);
			d1 = 64'(fade_len);
		end
		if (armed && frame >= stop) begin
			past_stop = 64'(frame - stop);
			if (fade_len == '0 || past_stop >= 64'(fade_len)) begin
				n2 = 64'd0;
			end else begin
				n2 = 64'(fade_len) - past_stop;
				d2 = 64'(fade_len);
			end
		end
		num = mag * 64'(gain) * n1 * n2;
		dv = d1 * d2 * 64'd65536;
		q = (num + dv / 64'd2) / dv;
		if (phase[31])
			return (q > 64'd32768) ? 16'sh8000 : stfe_pkg::SAMPLE_W'(-q);
		return (q > 64'd32767) ? 16'sh7fff : stfe_pkg::SAMPLE_W'(q);
	endfunction

	function automatic logic [stfe_pkg::FRAME_W-1:0] rand_frame();
		return {16'($urandom), $urandom};
	endfunction

	task automatic write_reg(input logic [stfe_pkg::CFG_IDX_W-1:0] idx,
		input logic [stfe_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			stfe_pkg::REG_PHASE_INC:  phase_inc = data[stfe_pkg::INC_W-1:0];
			stfe_pkg::REG_FADE_LEN:   fade_len = data[stfe_pkg::FADE_W-1:0];
			stfe_pkg::REG_BASE_GAIN:  gain = data[stfe_pkg::GAIN_W-1:0];
			stfe_pkg::REG_CHAN_COUNT: chan_count = data[stfe_pkg::COUNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic offer_frame(input logic [stfe_pkg::FRAME_W-1:0] frame, input logic armed,
		input logic [stfe_pkg::FRAME_W-1:0] stop);
		int gap;
		int n;
		chan_sample_t cs;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
			gap++;
		@(negedge clk);
		repeat (gap) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.frame_num <= frame;
		in_ch.stop_armed <= armed;
		in_ch.stop_frame <= stop;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		frames_sent++;
		n = (int'(chan_count) > CHANNELS_MAX) ? CHANNELS_MAX : int'(chan_count);
		cs.sample = tone_sample(frame, armed, stop);
		for (int c = 0; c < n; c++) begin
			cs.channel = stfe_pkg::CHAN_W'(c);
			cs.last_channel = (c == n - 1);
			pending_channel_samples.push_back(cs);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_channel_samples.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic play_stream(input int len);
		logic [stfe_pkg::FRAME_W-1:0] base, stop;
		logic armed;
		int span;
		span = int'(fade_len) + len;
		base = rand_frame();
		case ($urandom_range(3))
			0: base = stfe_pkg::FRAME_W'($urandom_range(0, span));
			1: base[31:0] = 32'hffff_ffff - 32'($urandom_range(0, len));
			2: base = 48'hffff_ffff_ffff - stfe_pkg::FRAME_W'($urandom_range(0, len));
			default: ;
		endcase
		armed = ($urandom_range(99) < 65);
		case ($urandom_range(2))
			0: stop = base + stfe_pkg::FRAME_W'($urandom_range(0, len));
			1: stop = base - stfe_pkg::FRAME_W'($urandom_range(0, span));
			default: stop = rand_frame();
		endcase
		for (int i = 0; i < len; i++)
			offer_frame(base + stfe_pkg::FRAME_W'(i), armed, stop);
	endtask

	task automatic randomize_config();
		logic [stfe_pkg::CFG_DATA_W-1:0] data;
		int r;
		write_reg(stfe_pkg::REG_PHASE_INC, $urandom);
		data = $urandom;
		r = $urandom_range(99);
		if (r < 10)
			data[stfe_pkg::FADE_W-1:0] = '0;
		else if (r < 60)
			data[stfe_pkg::FADE_W-1:0] = stfe_pkg::FADE_W'($urandom_range(1, 64));
		write_reg(stfe_pkg::REG_FADE_LEN, data);
		write_reg(stfe_pkg::REG_BASE_GAIN, $urandom);
		data = $urandom;
		r = $urandom_range(99);
		if (r < 85)
			data[stfe_pkg::COUNT_W-1:0] = stfe_pkg::COUNT_W'($urandom_range(1, CHANNELS_MAX));
		else if (r < 92)
			data[stfe_pkg::COUNT_W-1:0] = '0;
		else
			data[stfe_pkg::COUNT_W-1:0] = stfe_pkg::COUNT_W'($urandom_range(CHANNELS_MAX + 1, 15));
		write_reg(stfe_pkg::REG_CHAN_COUNT, data);
	endtask

	task automatic test_reset_defaults();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		offer_frame(48'd0, 1'b1, 48'd0);
		offer_frame(48'd480, 1'b0, rand_frame());
		offer_frame(48'd959, 1'b0, 48'd0);
		offer_frame(48'd960, 1'b0, 48'd0);
		offer_frame(48'd1000, 1'b1, 48'd2000);
		offer_frame(48'd5000, 1'b1, 48'd5000);
		offer_frame(48'd5959, 1'b1, 48'd5000);
		offer_frame(48'd5960, 1'b1, 48'd5000);
		offer_frame(48'hffff_ffff_ffff, 1'b1, 48'hffff_ffff_ffff);
		drain();
	endtask

	task automatic test_config_extremes();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		write_reg(stfe_pkg::REG_PHASE_INC, 32'hffff_ffff);
		write_reg(stfe_pkg::REG_FADE_LEN, 32'hffff_0000);
		write_reg(stfe_pkg::REG_BASE_GAIN, 32'h0000_ffff);
		write_reg(stfe_pkg::REG_CHAN_COUNT, 32'hffff_fff8);
		offer_frame(48'd0, 1'b0, 48'd0);
		offer_frame(48'd1, 1'b0, 48'd0);
		offer_frame(48'hffff_ffff_ffff, 1'b0, 48'd0);
		offer_frame(48'd100, 1'b1, 48'd100);
		offer_frame(48'd100, 1'b1, 48'd101);
		drain();
		// quarter-cycle steps land on the quadrant edges
		write_reg(stfe_pkg::REG_PHASE_INC, 32'h4000_0000);
		write_reg(stfe_pkg::REG_FADE_LEN, 32'h0000_ffff);
		offer_frame(48'd1, 1'b0, 48'd0);
		offer_frame(48'd2, 1'b0, 48'd0);
		offer_frame(48'd3, 1'b0, 48'd0);
		offer_frame(48'hfffe, 1'b1, 48'hfffe);
		offer_frame(48'hffff, 1'b1, 48'd1);
		drain();
		write_reg(stfe_pkg::REG_PHASE_INC, 32'd0);
		write_reg(stfe_pkg::REG_BASE_GAIN, 32'hffff_0000);
		offer_frame(48'd70000, 1'b0, 48'd0);
		drain();
	endtask

	task automatic test_channel_counts();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		write_reg(stfe_pkg::REG_PHASE_INC, $urandom);
		write_reg(stfe_pkg::REG_FADE_LEN, 32'd16);
		write_reg(stfe_pkg::REG_BASE_GAIN, 32'd40000);
		write_reg(stfe_pkg::REG_CHAN_COUNT, 32'd0);
		offer_frame(rand_frame(), 1'b0, rand_frame());
		offer_frame(48'd5, 1'b1, 48'd2);
		drain();
		write_reg(stfe_pkg::REG_CHAN_COUNT, 32'd15);
		offer_frame(48'd3, 1'b0, 48'd0);
		offer_frame(rand_frame(), 1'b1, 48'd0);
		drain();
		write_reg(stfe_pkg::REG_CHAN_COUNT, 32'd1);
		// writes to unused indexes must leave every register alone
		for (int i = int'(stfe_pkg::REG_CHAN_COUNT) + 1; i < 2 ** stfe_pkg::CFG_IDX_W; i++)
			write_reg(stfe_pkg::CFG_IDX_W'(i), $urandom);
		offer_frame(48'd7, 1'b0, 48'd0);
		offer_frame(rand_frame(), 1'b0, 48'd0);
		drain();
	endtask

	task automatic test_random_traffic();
		int tx_modes [4] = '{0, 55, 0, 13};
		int rx_modes [4] = '{0, 0, 55, 13};
		int left;
		int len;
		for (int m = 0; m < 4; m++) begin
			tx_idle_pct = tx_modes[m];
			rx_stall_pct = rx_modes[m];
			for (int s = 0; s < 3; s++) begin
				randomize_config();
				left = 15;
				while (left > 0) begin
					len = $urandom_range(3, 12);
					if (len > left)
						len = left;
					play_stream(len);
					left -= len;
				end
				drain();
			end
		end
	endtask

	task automatic test_back_pressure();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		randomize_config();
		write_reg(stfe_pkg::REG_CHAN_COUNT, 32'(CHANNELS_MAX));
		hold_off_cycles = 300;
		play_stream(15);
		play_stream(15);
		drain();
	endtask

	// receiver: random stalls plus an optional long hold-off
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				out_ch.ready <= 1'b0;
				hold_off_cycles--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_channel_samples
		chan_sample_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_channel_samples.size() == 0) begin
				$display("%0t: unexpected transaction sample %0d channel %0d last %0b",
					$time, out_ch.sample, out_ch.channel, out_ch.last_channel);
				mismatch_count++;
			end else begin
				want = pending_channel_samples.pop_front();
				samples_checked++;
				if (out_ch.sample !== want.sample) begin
					$display("%0t: sample expected %0d actual %0d", $time,
						want.sample, out_ch.sample);
					mismatch_count++;
				end
				if (out_ch.channel !== want.channel) begin
					$display("%0t: channel expected %0d actual %0d", $time,
						want.channel, out_ch.channel);
					mismatch_count++;
				end
				if (out_ch.last_channel !== want.last_channel) begin
					$display("%0t: last_channel expected %0b actual %0b", $time,
						want.last_channel, out_ch.last_channel);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.frame_num = '0;
		in_ch.stop_armed = 1'b0;
		in_ch.stop_frame = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_off_cycles = 0;
		mismatch_count = 0;
		frames_sent = 0;
		samples_checked = 0;
		phase_inc = stfe_pkg::INC_RESET;
		fade_len = stfe_pkg::FADE_RESET;
		gain = stfe_pkg::GAIN_RESET;
		chan_count = stfe_pkg::COUNT_RESET;
		for (int k = 0; k < TABLE_DEPTH; k++)
			quarter_sine_lut[k] = quarter_wave(k);
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		test_reset_defaults();
		test_config_extremes();
		test_channel_counts();
		test_random_traffic();
		test_back_pressure();

		$display("Checked %0d channel samples from %0d frames: default and extreme registers,",
			samples_checked, frames_sent);
		$display("fade edges, channel counts 0 to 15, idle and stall mixes, long receiver hold-off");
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/stfe_pkg.sv
rtl/stfe_ifs.sv
rtl/sine_tone_with_fade_envelope_top.sv
rtl/stfe_checker.sv
sim/sine_tone_with_fade_envelope_top_test.sv
